/* rtl/ddm_pkg.sv */
// Package: payload types and constants for the decimal digit multiplier
`timescale 1ns / 1ps
`default_nettype none
package ddm_pkg;
	localparam int unsigned MAX_DIGITS = 16;
	localparam int unsigned PROD_DIGITS = 32;
	localparam logic [3:0] MAX_BCD = 4'd9;

	typedef struct packed {
		logic [63:0] a_digits;
		logic [63:0] b_digits;
		logic [4:0]  a_length;
		logic [4:0]  b_length;
	} ddm_in_t;

	typedef struct packed {
		logic [63:0] product_low;
		logic [63:0] product_high;
		logic [5:0]  product_length;
		logic        bad_digit;
	} ddm_out_t;

	// column sum of up to 16 products of 81, plus carry-in below 160
	typedef logic [10:0] ddm_col_t;
endpackage
`default_nettype wire

/* rtl/ddm_carry_stage.sv */
// Module: one registered decimal carry step over a group of product columns
`timescale 1ns / 1ps
`default_nettype none
module ddm_carry_stage
	import ddm_pkg::*;
#(
	parameter int unsigned LO = 0,
	parameter int unsigned HI = 7
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic                    vld_in,
	input  wire ddm_col_t [PROD_DIGITS-1:0] col_in,
	input  wire logic [7:0]              cy_in,
	input  wire logic [5:0]              len_in,
	input  wire logic                    bad_in,
	output logic                         vld_s,
	output ddm_col_t [PROD_DIGITS-1:0]   col_s,
	output logic [7:0]                   cy_s,
	output logic [5:0]                   len_s,
	output logic                         bad_s
);
	ddm_col_t [PROD_DIGITS-1:0] col_d;
	logic [7:0] cy_d;

	// ripple carry through columns LO..HI, leaving single digits behind
	// divide by ten as multiply by 3277 and shift by 15, exact below 16384
	always_comb begin
		logic [11:0] s;
		logic [7:0] c;
		col_d = col_in;
		c = cy_in;
		for (int i = LO; i <= HI; i++) begin
			s = {1'b0, col_in[i]} + {4'd0, c};
			c = 8'((24'(s) * 24'd3277) >> 15);
			col_d[i] = ddm_col_t'(s - 12'(c) * 12'd10);
		end
		cy_d = c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (adv) begin
			vld_s <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s <= col_d;
			cy_s  <= cy_d;
			len_s <= len_in;
			bad_s <= bad_in;
		end
	end
endmodule
`default_nettype wire

/* rtl/decimal_digit_multiplier.sv */
// Top level: pipelined packed BCD multiplier
// Throughput: one word per cycle; a stall freezes the whole pipeline in place.
// Stages: digit products, column sums, eight carry-ripple stages, output register.
// Reset: arst_n clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module decimal_digit_multiplier
	import ddm_pkg::*;
#(
	parameter int unsigned DIGITS = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire ddm_in_t in_word,
	output logic         out_valid,
	input  wire logic    out_stall,
	output ddm_out_t     out_word
);
	localparam logic [4:0] LIM = 5'(DIGITS);

	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: length clamp, digit masking, digit check, digit products
	logic [4:0] la, lb;
	logic [3:0] da [MAX_DIGITS], db [MAX_DIGITS];
	logic bad_d;
	always_comb begin
		la = (in_word.a_length > LIM) ? LIM : in_word.a_length;
		lb = (in_word.b_length > LIM) ? LIM : in_word.b_length;
		bad_d = 1'b0;
		for (int n = 0; n < MAX_DIGITS; n++) begin
			da[n] = (5'(n) < la) ? in_word.a_digits[4*n +: 4] : 4'd0;
			db[n] = (5'(n) < lb) ? in_word.b_digits[4*n +: 4] : 4'd0;
			if (da[n] > MAX_BCD || db[n] > MAX_BCD) bad_d = 1'b1;
		end
	end

	logic       vld_s1, bad_s1;
	logic [5:0] len_s1;
	logic [6:0] pp_s1 [MAX_DIGITS][MAX_DIGITS];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			len_s1 <= {1'b0, la} + {1'b0, lb};
			bad_s1 <= bad_d;
			for (int p = 0; p < MAX_DIGITS; p++)
				for (int q = 0; q < MAX_DIGITS; q++)
					pp_s1[p][q] <= 7'(da[p] * db[q]);
		end
	end

	// stage 2: column sums; a bad digit forces a zero product
	ddm_col_t [PROD_DIGITS-1:0] col_d, col_s2;
	always_comb begin
		for (int k = 0; k < PROD_DIGITS; k++) begin
			col_d[k] = '0;
			for (int p = 0; p < MAX_DIGITS; p++)
				if (k - p >= 0 && k - p < MAX_DIGITS)
					col_d[k] = col_d[k] + ddm_col_t'(pp_s1[p][k-p]);
			if (bad_s1) col_d[k] = '0;
		end
	end
	logic       vld_s2, bad_s2;
	logic [5:0] len_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			col_s2 <= col_d;
			len_s2 <= len_s1;
			bad_s2 <= bad_s1;
		end
	end

	// stages 3-10: carry ripple, four columns per stage
	logic       vld_c [9];
	ddm_col_t [PROD_DIGITS-1:0] col_c [9];
	logic [7:0] cy_c [9];
	logic [5:0] len_c [9];
	logic       bad_c [9];
	assign vld_c[0] = vld_s2;
	assign col_c[0] = col_s2;
	assign cy_c[0]  = '0;
	assign len_c[0] = len_s2;
	assign bad_c[0] = bad_s2;
	for (genvar g = 0; g < 8; g++) begin : g_cy
		ddm_carry_stage #(.LO(4*g), .HI(4*g+3)) u_cy (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vld_in(vld_c[g]), .col_in(col_c[g]), .cy_in(cy_c[g]),
			.len_in(len_c[g]), .bad_in(bad_c[g]),
			.vld_s(vld_c[g+1]), .col_s(col_c[g+1]), .cy_s(cy_c[g+1]),
			.len_s(len_c[g+1]), .bad_s(bad_c[g+1])
		);
	end

	// output register: pack digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vld_c[8];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < MAX_DIGITS; n++) begin
				out_word.product_low[4*n +: 4]  <= col_c[8][n][3:0];
				out_word.product_high[4*n +: 4] <= col_c[8][n+MAX_DIGITS][3:0];
			end
			out_word.product_length <= len_c[8];
			out_word.bad_digit      <= bad_c[8];
		end
	end
endmodule
`default_nettype wire

/* rtl/ddm_checker.sv */
// Checker: port-level properties of the decimal digit multiplier
`timescale 1ns / 1ps
`default_nettype none
module ddm_checker
	import ddm_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_stall,
	input wire ddm_in_t  in_word,
	input wire logic     out_valid,
	input wire logic     out_stall,
	input wire ddm_out_t out_word
);
	// a stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output word changed");

	// a stalled input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_word))
		else $error("stalled input word changed");

	// input stall only mirrors an output stall with valid output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// bad digit implies zero product
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.bad_digit |->
		out_word.product_low == '0 && out_word.product_high == '0)
		else $error("bad digit with nonzero product");

	// product length never exceeds 32
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.product_length <= 6'd32)
		else $error("product length out of range");
endmodule

bind decimal_digit_multiplier ddm_checker u_ddm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
	.out_word(out_word)
);
`default_nettype wire
